FILE: rtl/tfs_pkg.sv
// Shared types and codes for the three-level feedback scheduler.
`timescale 1ns / 1ps
package tfs_pkg;

	typedef enum logic [1:0] {
		LVL_TOP = 2'd0,
		LVL_MID = 2'd1,
		LVL_LOW = 2'd2
	} level_t;

	typedef enum logic [1:0] {
		ST_ADDED    = 2'd0,
		ST_REJECTED = 2'd1,
		ST_RAN      = 2'd2,
		ST_IDLE     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} state_t;

	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [2:0] CFG_SLICE_TOP = 3'd0;
	localparam logic [2:0] CFG_SLICE_MID = 3'd1;
	localparam logic [2:0] CFG_SLICE_LOW = 3'd2;
	localparam logic [2:0] CFG_GAIN_TOP  = 3'd3;
	localparam logic [2:0] CFG_GAIN_MID  = 3'd4;
	localparam logic [2:0] CFG_LIMIT_TOP = 3'd5;
	localparam logic [2:0] CFG_LIMIT_MID = 3'd6;
	localparam logic [2:0] CFG_LIMIT_LOW = 3'd7;

	// penalty gain of the low queue is fixed
	localparam logic [3:0] LOW_GAIN = 4'd1;

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] time_rem;
		logic [4:0] pen;
	} entry_t;

endpackage

FILE: rtl/tfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tfs_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 48,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/three_level_feedback_scheduler_unit.sv
// Top level of the three-level feedback scheduler: control, pointers, config and output word.
//
//  channel | signals                                   | direction | handshake
//  --------+-------------------------------------------+-----------+----------------
//  in      | req_type, run_time                        | in        | in_valid/in_stall
//  out     | status, job_id, level_ran, time_left,     | out       | out_valid/out_stall
//          | penalty_after, finished, moved, moved_to  |           |
//  cfg     | psel, penable, pwrite, paddr, pwdata      | in        | APB, pready = 1
//
// An add or an idle tick is done in S_IDLE; a tick that runs a job also passes
// through S_RUN, as the queue RAM read data is registered before its write-back.
// One word is worked on at a time; a new word is taken once the output register
// is empty or being drained. Reset clears pointers and counts, loads the config
// defaults, next id is 1.
// The queue RAM needs no clearing pass: only written entries are ever read.
`timescale 1ns / 1ps
module three_level_feedback_scheduler_unit #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  run_time,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  job_id,
	output logic [1:0]  level_ran,
	output logic [7:0]  time_left,
	output logic [4:0]  penalty_after,
	output logic        finished,
	output logic        moved,
	output logic [1:0]  moved_to,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int RD = 3 * DEPTH;
	localparam int AW = $clog2(RD);
	localparam int EW = $bits(tfs_pkg::entry_t);

	// config registers
	logic [7:0] slice_top_q, slice_mid_q, slice_low_q;
	logic [3:0] gain_top_q, gain_mid_q;
	logic [3:0] limit_top_q, limit_mid_q, limit_low_q;

	// queue bookkeeping
	logic [PW-1:0] head_q [3];
	logic [PW-1:0] tail_q [3];
	logic [CW-1:0] cnt_q  [3];
	logic [PW-1:0] head_d [3];
	logic [PW-1:0] tail_d [3];
	logic [CW-1:0] cnt_d  [3];
	logic [CW-1:0] total_q, total_d;
	logic [7:0]    next_id_q, next_id_d;

	tfs_pkg::state_t state_q, state_d;
	tfs_pkg::level_t lvl_s1, sel_lvl, push_lvl, dest_lvl;
	logic            any_job;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	tfs_pkg::entry_t ent, wr_ent;

	// run computation
	logic [7:0] slice_v, left_v;
	logic [3:0] gain_v, limit_v;
	logic [4:0] pen_v;
	logic       fin_v, move_v;

	// output word
	logic       accept, load_out;
	logic       out_valid_q;
	logic [1:0] o_status_d, o_status_q;
	logic [7:0] o_id_d, o_id_q;
	logic [1:0] o_lvl_d, o_lvl_q;
	logic [7:0] o_left_d, o_left_q;
	logic [4:0] o_pen_d, o_pen_q;
	logic       o_fin_d, o_fin_q;
	logic       o_moved_d, o_moved_q;
	logic [1:0] o_to_d, o_to_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [AW-1:0] slot(input tfs_pkg::level_t l, input logic [PW-1:0] p);
		return AW'(l) * AW'(DEPTH) + AW'(p);
	endfunction

	tfs_ram #(
		.WIDTH(EW),
		.DEPTH(RD)
	) u_queue_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_top_q <= 8'd1;
			slice_mid_q <= 8'd1;
			slice_low_q <= 8'd1;
			gain_top_q  <= 4'd1;
			gain_mid_q  <= 4'd1;
			limit_top_q <= 4'd2;
			limit_mid_q <= 4'd2;
			limit_low_q <= 4'd4;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				tfs_pkg::CFG_SLICE_TOP: slice_top_q <= pwdata[7:0];
				tfs_pkg::CFG_SLICE_MID: slice_mid_q <= pwdata[7:0];
				tfs_pkg::CFG_SLICE_LOW: slice_low_q <= pwdata[7:0];
				tfs_pkg::CFG_GAIN_TOP:  gain_top_q  <= pwdata[3:0];
				tfs_pkg::CFG_GAIN_MID:  gain_mid_q  <= pwdata[3:0];
				tfs_pkg::CFG_LIMIT_TOP: limit_top_q <= pwdata[3:0];
				tfs_pkg::CFG_LIMIT_MID: limit_mid_q <= pwdata[3:0];
				tfs_pkg::CFG_LIMIT_LOW: limit_low_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			tfs_pkg::CFG_SLICE_TOP: prdata = {24'd0, slice_top_q};
			tfs_pkg::CFG_SLICE_MID: prdata = {24'd0, slice_mid_q};
			tfs_pkg::CFG_SLICE_LOW: prdata = {24'd0, slice_low_q};
			tfs_pkg::CFG_GAIN_TOP:  prdata = {28'd0, gain_top_q};
			tfs_pkg::CFG_GAIN_MID:  prdata = {28'd0, gain_mid_q};
			tfs_pkg::CFG_LIMIT_TOP: prdata = {28'd0, limit_top_q};
			tfs_pkg::CFG_LIMIT_MID: prdata = {28'd0, limit_mid_q};
			tfs_pkg::CFG_LIMIT_LOW: prdata = {28'd0, limit_low_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------- level select and run math ----------------
	always_comb begin
		any_job = 1'b1;
		if (cnt_q[0] != '0) begin
			sel_lvl = tfs_pkg::LVL_TOP;
		end else if (cnt_q[1] != '0) begin
			sel_lvl = tfs_pkg::LVL_MID;
		end else begin
			sel_lvl = tfs_pkg::LVL_LOW;
			any_job = (cnt_q[2] != '0);
		end
	end

	assign ent = tfs_pkg::entry_t'(ram_rdata);

	always_comb begin
		case (lvl_s1)
			tfs_pkg::LVL_TOP: begin
				slice_v  = slice_top_q;
				gain_v   = gain_top_q;
				limit_v  = limit_top_q;
				dest_lvl = tfs_pkg::LVL_MID;
			end
			tfs_pkg::LVL_MID: begin
				slice_v  = slice_mid_q;
				gain_v   = gain_mid_q;
				limit_v  = limit_mid_q;
				dest_lvl = tfs_pkg::LVL_LOW;
			end
			default: begin
				slice_v  = slice_low_q;
				gain_v   = tfs_pkg::LOW_GAIN;
				limit_v  = limit_low_q;
				dest_lvl = tfs_pkg::LVL_TOP;
			end
		endcase
		left_v = (ent.time_rem > slice_v) ? ent.time_rem - slice_v : 8'd0;
		pen_v  = ent.pen + {1'b0, gain_v};
		fin_v  = (left_v == 8'd0);
		move_v = !fin_v && (pen_v >= {1'b0, limit_v});
	end

	// ---------------- control ----------------
	assign in_stall = (state_q != tfs_pkg::S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d   = state_q;
		total_d   = total_q;
		next_id_d = next_id_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cnt_d     = cnt_q;
		ram_we    = 1'b0;
		ram_raddr = slot(sel_lvl, head_q[sel_lvl]);
		ram_waddr = slot(tfs_pkg::LVL_TOP, tail_q[0]);
		wr_ent    = '{id: next_id_q, time_rem: run_time, pen: 5'd0};
		push_lvl  = lvl_s1;
		load_out  = 1'b0;
		o_status_d = tfs_pkg::ST_ADDED;
		o_id_d     = 8'd0;
		o_lvl_d    = 2'd0;
		o_left_d   = 8'd0;
		o_pen_d    = 5'd0;
		o_fin_d    = 1'b0;
		o_moved_d  = 1'b0;
		o_to_d     = 2'd0;

		case (state_q)
			tfs_pkg::S_IDLE: begin
				if (accept) begin
					if (req_type == tfs_pkg::REQ_ADD) begin
						load_out = 1'b1;
						if (total_q >= CW'(DEPTH)) begin
							o_status_d = tfs_pkg::ST_REJECTED;
						end else begin
							ram_we     = 1'b1;
							tail_d[0]  = bump(tail_q[0]);
							cnt_d[0]   = cnt_q[0] + CW'(1);
							total_d    = total_q + CW'(1);
							next_id_d  = next_id_q + 8'd1;
							o_status_d = tfs_pkg::ST_ADDED;
							o_id_d     = next_id_q;
						end
					end else if (!any_job) begin
						load_out   = 1'b1;
						o_status_d = tfs_pkg::ST_IDLE;
					end else begin
						// head read issued now, data comes back next cycle
						state_d = tfs_pkg::S_RUN;
					end
				end
			end
			tfs_pkg::S_RUN: begin
				state_d          = tfs_pkg::S_IDLE;
				load_out         = 1'b1;
				head_d[lvl_s1]   = bump(head_q[lvl_s1]);
				cnt_d[lvl_s1]    = cnt_q[lvl_s1] - CW'(1);
				o_status_d       = tfs_pkg::ST_RAN;
				o_id_d           = ent.id;
				o_lvl_d          = lvl_s1;
				o_left_d         = left_v;
				o_pen_d          = pen_v;
				o_fin_d          = fin_v;
				if (fin_v) begin
					total_d = total_q - CW'(1);
				end else begin
					push_lvl  = move_v ? dest_lvl : lvl_s1;
					wr_ent    = '{id: ent.id, time_rem: left_v,
					              pen: (move_v ? 5'd0 : pen_v)};
					ram_we    = 1'b1;
					ram_waddr = slot(push_lvl, tail_q[push_lvl]);
					tail_d[push_lvl] = bump(tail_q[push_lvl]);
					// same-level re-queue nets the count out
					cnt_d[push_lvl]  = (push_lvl == lvl_s1) ? cnt_q[push_lvl]
					                                        : cnt_q[push_lvl] + CW'(1);
					o_moved_d = move_v;
					o_to_d    = push_lvl;
				end
			end
			default: state_d = tfs_pkg::S_IDLE;
		endcase
	end

	assign ram_wdata = wr_ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tfs_pkg::S_IDLE;
			total_q     <= '0;
			next_id_q   <= 8'd1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			state_q   <= state_d;
			total_q   <= total_d;
			next_id_q <= next_id_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			cnt_q     <= cnt_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_s1 <= sel_lvl;
		end
		if (load_out) begin
			o_status_q <= o_status_d;
			o_id_q     <= o_id_d;
			o_lvl_q    <= o_lvl_d;
			o_left_q   <= o_left_d;
			o_pen_q    <= o_pen_d;
			o_fin_q    <= o_fin_d;
			o_moved_q  <= o_moved_d;
			o_to_q     <= o_to_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign job_id        = o_id_q;
	assign level_ran     = o_lvl_q;
	assign time_left     = o_left_q;
	assign penalty_after = o_pen_q;
	assign finished      = o_fin_q;
	assign moved         = o_moved_q;
	assign moved_to      = o_to_q;

endmodule
